// ===== design/exlex_pkg.sv =====
// ----------------------------------------------------------------------------
// exlex_pkg
// Shared types and constants for the expression lexer.
// ----------------------------------------------------------------------------
package exlex_pkg;

  // Default width of line positions inside the scanner.
  localparam int unsigned POS_BITS_DEF = 16;
  // Width of position and length fields on the result channel.
  localparam int unsigned OUT_POS_W    = 16;
  // Tokens one source byte can cause at most.
  localparam int unsigned NUM_SLOTS    = 3;
  // Default depth of the token-group queue.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    TK_IDENT  = 4'd0,
    TK_CONST  = 4'd1,
    TK_NUMBER = 4'd2,
    TK_OPER   = 4'd3,
    TK_OPEN   = 4'd4,
    TK_CLOSE  = 4'd5,
    TK_EQUAL  = 4'd6,
    TK_SEMI   = 4'd7,
    TK_END    = 4'd8,
    TK_ERROR  = 4'd9
  } token_kind_e;

  typedef struct packed {
    token_kind_e          kind;
    logic [7:0]           chr;
    logic [OUT_POS_W-1:0] start;
    logic [OUT_POS_W-1:0] length;
  } token_t;

  // All tokens caused by one source byte, in emission order.
  typedef struct packed {
    logic   [NUM_SLOTS-1:0] vld;
    token_t [NUM_SLOTS-1:0] tok;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== design/exlex_in_if.sv =====
// ----------------------------------------------------------------------------
// exlex_in_if
// Source byte channel: valid/ready handshake with one character per request.
// ----------------------------------------------------------------------------
interface exlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_end;
  logic       no_char;

  modport source (output valid, output char_byte, output is_end, output no_char,
                  input ready);
  modport sink   (input valid, input char_byte, input is_end, input no_char,
                  output ready);
endinterface

// ===== design/exlex_out_if.sv =====
// ----------------------------------------------------------------------------
// exlex_out_if
// Token channel: valid/ready handshake with one token per request.
// ----------------------------------------------------------------------------
interface exlex_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  token_char;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_char,
                  output start_pos, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_char,
                  input start_pos, input token_length, input last_of_run,
                  output ready);
endinterface

// ===== design/expression_lexer_top.sv =====
// ----------------------------------------------------------------------------
// expression_lexer_top
// Streaming tokenizer for simple expressions: one source byte per request in,
// one token (kind, character, start, length) per request out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  in_i     | in  | valid/ready        | char_byte, is_end, no_char
//  out_o    | out | valid/ready        | token_kind, token_char, start_pos,
//           |     |                    | token_length, last_of_run
//
//  One source byte is taken every cycle while the group queue has room; the
//  first token of a byte passes the queue, then the output register. A byte
//  giving k tokens (k up to 3) stays at the queue head until all k are loaded,
//  so the token port, one token per cycle while out_o is ready, sets the rate.
//  Reset: rst_ni clears scan state, queue pointers and output valid at once.
//  Stalls: out_o back-pressure fills the queue, then in_i.ready drops; bytes
//  that give no token never enter the queue.
//
// Structure
//  exlex_front - classifies the byte, tracks mode/position/keyword match and
//                builds up to three tokens for it combinationally.
//  exlex_queue - short FIFO of token groups, decouples the two halves.
//  exlex_back  - walks the slots of the head group into a registered output.
//
// Token order within a group: a token closed by this byte, then the single
// character token (or error, or the token closed by the line end), then the
// end-of-line token. Positions saturate at the all-ones value of PosBits.
// ----------------------------------------------------------------------------
module expression_lexer_top #(
  parameter int unsigned PosBits    = exlex_pkg::POS_BITS_DEF,
  parameter int unsigned QueueDepth = exlex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  exlex_in_if.sink    in_i,
  exlex_out_if.source out_o
);

  exlex_pkg::group_t      push_grp;
  exlex_pkg::group_t      head_grp;
  exlex_pkg::queue_stat_t q_stat;
  logic                   push;
  logic                   pop;

  // front: classification and scan state
  exlex_front #(
    .PosBits (PosBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .grp_o    (push_grp)
  );

  // token groups waiting for the output side
  exlex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (push_grp),
    .pop_i  (pop),
    .head_o (head_grp),
    .stat_o (q_stat)
  );

  // back: one token per request on out_o
  exlex_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_grp),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

// ===== design/exlex_front.sv =====
// ----------------------------------------------------------------------------
// exlex_front
// Byte classifier and scan state; builds the token group for each byte.
// ----------------------------------------------------------------------------
module exlex_front #(
  parameter int unsigned PosBits = exlex_pkg::POS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  exlex_in_if.sink             in_i,
  input  exlex_pkg::queue_stat_t q_stat_i,
  output logic                 push_o,
  output exlex_pkg::group_t    grp_o
);

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_NUM   = 2'd1,
    M_IDENT = 2'd2,
    M_DROP  = 2'd3
  } mode_e;

  localparam logic [2:0] KwDone = 3'd5;
  localparam logic [2:0] KwDead = 3'd7;
  localparam logic [2:0] KwOne  = 3'd1;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLowC  = 8'h63;

  localparam logic [PosBits-1:0] PosMax = '1;

  // Expected character of "const" at a given match count.
  function automatic logic [7:0] kw_char(input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0:    r = 8'h63;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h6E;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [exlex_pkg::OUT_POS_W-1:0] to_out(
    input logic [PosBits-1:0] v
  );
    logic [31:0] w;
    w = 32'(v);
    return w[exlex_pkg::OUT_POS_W-1:0];
  endfunction

  mode_e              mode_q, mode_d, mode_a;
  logic [PosBits-1:0] tstart_q, tstart_d, tstart_a;
  logic [PosBits-1:0] pos_q, pos_d, pos_a;
  logic [2:0]         kw_q, kw_d, kw_a;

  logic [7:0] c;
  logic       is_dig, is_let, is_spc, accept;
  exlex_pkg::group_t grp;

  assign c      = in_i.char_byte;
  assign is_dig = (c >= ChZero) && (c <= ChNine);
  assign is_let = ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ));
  assign is_spc = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    grp      = '0;
    mode_a   = mode_q;
    tstart_a = tstart_q;
    kw_a     = kw_q;
    pos_a    = pos_q;

    if (!in_i.no_char) begin
      // close an open token that this byte ends
      unique case (mode_q)
        M_NUM: begin
          if (!is_dig) begin
            grp.vld[0] = 1'b1;
            grp.tok[0] = '{kind: exlex_pkg::TK_NUMBER, chr: 8'h00,
                           start: to_out(tstart_q), length: to_out(pos_q - tstart_q)};
            mode_a = M_IDLE;
          end
        end
        M_IDENT: begin
          if (is_let || is_dig) begin
            kw_a = ((kw_q < KwDone) && (kw_char(kw_q) == c)) ? kw_q + 3'd1 : KwDead;
          end else begin
            grp.vld[0] = 1'b1;
            grp.tok[0] = '{kind: (kw_q == KwDone) ? exlex_pkg::TK_CONST
                                                   : exlex_pkg::TK_IDENT,
                           chr: 8'h00, start: to_out(tstart_q),
                           length: to_out(pos_q - tstart_q)};
            mode_a = M_IDLE;
          end
        end
        M_IDLE: ;
        M_DROP: ;
      endcase

      if (mode_a == M_IDLE && !is_spc) begin
        if (is_dig) begin
          mode_a   = M_NUM;
          tstart_a = pos_q;
        end else if (is_let) begin
          mode_a   = M_IDENT;
          tstart_a = pos_q;
          kw_a     = (c == ChLowC) ? KwOne : KwDead;
        end else begin
          grp.vld[1] = 1'b1;
          grp.tok[1] = '{kind: exlex_pkg::TK_ERROR, chr: c,
                         start: to_out(pos_q), length: 16'd1};
          case (c) inside
            ChPlus, ChMinus, ChStar, ChSlash: grp.tok[1].kind = exlex_pkg::TK_OPER;
            ChOpen:  begin grp.tok[1].kind = exlex_pkg::TK_OPEN;  grp.tok[1].chr = 8'h00; end
            ChClose: begin grp.tok[1].kind = exlex_pkg::TK_CLOSE; grp.tok[1].chr = 8'h00; end
            ChEqual: begin grp.tok[1].kind = exlex_pkg::TK_EQUAL; grp.tok[1].chr = 8'h00; end
            ChSemi:  begin grp.tok[1].kind = exlex_pkg::TK_SEMI;  grp.tok[1].chr = 8'h00; end
            default: mode_a = M_DROP;
          endcase
        end
      end

      pos_a = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
    end

    if (in_i.is_end) begin
      // open token closes at the saturated position past the last byte
      if (mode_a == M_NUM || mode_a == M_IDENT) begin
        grp.vld[1] = 1'b1;
        grp.tok[1] = '{kind: (mode_a == M_NUM) ? exlex_pkg::TK_NUMBER :
                             (kw_a == KwDone) ? exlex_pkg::TK_CONST : exlex_pkg::TK_IDENT,
                       chr: 8'h00, start: to_out(tstart_a),
                       length: to_out(pos_a - tstart_a)};
      end
      grp.vld[2] = 1'b1;
      grp.tok[2] = '{kind: exlex_pkg::TK_END, chr: 8'h00,
                     start: to_out(pos_a), length: 16'd0};
      mode_d   = M_IDLE;
      tstart_d = '0;
      pos_d    = '0;
      kw_d     = '0;
    end else begin
      mode_d   = mode_a;
      tstart_d = tstart_a;
      pos_d    = pos_a;
      kw_d     = kw_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      tstart_q <= '0;
      pos_q    <= '0;
      kw_q     <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      pos_q    <= pos_d;
      kw_q     <= kw_d;
    end
  end

  assign push_o = accept && (|grp.vld);
  assign grp_o  = grp;

  // A line end leaves the scanner as after reset.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.is_end) |=> (mode_q == M_IDLE && pos_q == '0 && kw_q == '0))
    else $error("scan state not cleared after line end");

  // Dropped bytes cause nothing until the line ends.
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == M_DROP && !in_i.is_end) |-> !push_o)
    else $error("token produced while dropping");

endmodule

// ===== design/exlex_queue.sv =====
// ----------------------------------------------------------------------------
// exlex_queue
// Short FIFO of token groups between classifier and serialiser.
// ----------------------------------------------------------------------------
module exlex_queue #(
  parameter int unsigned Depth = exlex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  exlex_pkg::group_t      grp_i,
  input  logic                   pop_i,
  output exlex_pkg::group_t      head_o,
  output exlex_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  exlex_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full) && !(pop_i && stat_o.empty))
    else $error("queue overrun or underrun");

endmodule

// ===== design/exlex_back.sv =====
// ----------------------------------------------------------------------------
// exlex_back
// Serialises each token group into single tokens on a registered output.
// ----------------------------------------------------------------------------
module exlex_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  exlex_pkg::group_t      head_i,
  input  exlex_pkg::queue_stat_t q_stat_i,
  output logic                   pop_o,
  exlex_out_if.source            out_o
);

  localparam int unsigned SelW = $clog2(exlex_pkg::NUM_SLOTS);

  logic [SelW-1:0]               sel_q, idx;
  logic [exlex_pkg::NUM_SLOTS-1:0] avail;
  logic                          found, more, load;
  logic                          vld_q, last_q;
  exlex_pkg::token_t             tok_q;

  // pick the first pending slot and see whether any follow it
  always_comb begin
    found = 1'b0;
    more  = 1'b0;
    idx   = '0;
    for (int i = 0; i < exlex_pkg::NUM_SLOTS; i++) begin
      avail[i] = head_i.vld[i] && (SelW'(i) >= sel_q);
    end
    for (int i = 0; i < exlex_pkg::NUM_SLOTS; i++) begin
      if (avail[i]) begin
        if (found) begin
          more = 1'b1;
        end else begin
          found = 1'b1;
          idx   = SelW'(i);
        end
      end
    end
  end

  assign load  = (!vld_q || out_o.ready) && !q_stat_i.empty;
  assign pop_o = load && !more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        sel_q <= more ? idx + 1'b1 : '0;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= head_i.tok[idx];
      last_q <= !more;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.token_kind   = tok_q.kind;
  assign out_o.token_char   = tok_q.chr;
  assign out_o.start_pos    = tok_q.start;
  assign out_o.token_length = tok_q.length;
  assign out_o.last_of_run  = last_q;

  // Mid-group means the group is still at the queue head with a slot left.
  a_group_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != '0) |-> (!q_stat_i.empty && found))
    else $error("group left mid-way");

endmodule

// ===== test/exlex_token_checker.sv =====
// ----------------------------------------------------------------------------
// exlex_token_checker
// Watches both channels of the expression lexer, predicts the tokens of each
// accepted source byte and compares them with the tokens that leave the block.
// ----------------------------------------------------------------------------
module exlex_token_checker #(
  parameter int unsigned PosBits = exlex_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  exlex_in_if         in_mon,
  exlex_out_if        out_mon,
  output int unsigned due_cnt_o,
  output int unsigned mismatch_cnt_o,
  output int unsigned checked_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned         OW         = exlex_pkg::OUT_POS_W;
  localparam int unsigned         REPORT_MAX = 10;
  localparam logic [PosBits-1:0]  POS_LAST   = '1;
  localparam logic [PosBits-1:0]  ONE_CHAR   = PosBits'(1);
  localparam logic [2:0]          KW_FULL    = 3'd5;
  localparam logic [2:0]          KW_DEAD    = 3'd7;
  localparam string               KW_TEXT    = "const";

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUM,
    SCAN_IDENT,
    SCAN_DROP
  } scan_mode_e;

  typedef struct packed {
    exlex_pkg::token_t tok;
    logic              last;
  } token_due_t;

  // Scanner copy
  scan_mode_e         mode      = SCAN_IDLE;
  logic [PosBits-1:0] tok_start = '0;
  logic [PosBits-1:0] pos       = '0;
  logic [2:0]         kw_prog   = '0;

  token_due_t  tokens_due[$];
  token_due_t  byte_toks[$];
  int unsigned mismatches = 0;
  int unsigned checked    = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void put_token(exlex_pkg::token_kind_e kind, logic [7:0] chr,
                                    logic [PosBits-1:0] start,
                                    logic [PosBits-1:0] len);
    token_due_t t;
    t.tok.kind   = kind;
    t.tok.chr    = chr;
    t.tok.start  = OW'(start);
    t.tok.length = OW'(len);
    t.last       = 1'b0;
    byte_toks    = {byte_toks, t};
  endfunction

  function automatic void close_token();
    logic [PosBits-1:0] span;
    span = pos - tok_start;
    if (mode == SCAN_NUM) begin
      put_token(exlex_pkg::TK_NUMBER, 8'h00, tok_start, span);
      mode = SCAN_IDLE;
    end else if (mode == SCAN_IDENT) begin
      put_token((kw_prog == KW_FULL) ? exlex_pkg::TK_CONST : exlex_pkg::TK_IDENT,
                8'h00, tok_start, span);
      mode = SCAN_IDLE;
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (mode == SCAN_DROP) return;
    if (mode == SCAN_NUM) begin
      if (is_digit(c)) return;
      close_token();
    end else if (mode == SCAN_IDENT) begin
      if (is_letter(c) || is_digit(c)) begin
        if (kw_prog < KW_FULL && KW_TEXT[kw_prog] == c) kw_prog = kw_prog + 3'd1;
        else kw_prog = KW_DEAD;
        return;
      end
      close_token();
    end
    if (is_space(c)) return;
    if (is_digit(c)) begin
      mode      = SCAN_NUM;
      tok_start = pos;
      return;
    end
    if (is_letter(c)) begin
      mode      = SCAN_IDENT;
      tok_start = pos;
      kw_prog   = (c == "c") ? 3'd1 : KW_DEAD;
      return;
    end
    case (c)
      "+", "-", "*", "/": put_token(exlex_pkg::TK_OPER, c, pos, ONE_CHAR);
      "(":                put_token(exlex_pkg::TK_OPEN, 8'h00, pos, ONE_CHAR);
      ")":                put_token(exlex_pkg::TK_CLOSE, 8'h00, pos, ONE_CHAR);
      "=":                put_token(exlex_pkg::TK_EQUAL, 8'h00, pos, ONE_CHAR);
      ";":                put_token(exlex_pkg::TK_SEMI, 8'h00, pos, ONE_CHAR);
      default: begin
        put_token(exlex_pkg::TK_ERROR, c, pos, ONE_CHAR);
        mode = SCAN_DROP;
      end
    endcase
  endfunction

  function automatic void clear_scan();
    mode      = SCAN_IDLE;
    tok_start = '0;
    pos       = '0;
    kw_prog   = '0;
  endfunction

  // Tokens one accepted source request gives, queued in emission order.
  function automatic void predict_tokens(logic [7:0] c, logic line_end, logic none);
    byte_toks.delete();
    if (!none) begin
      take_char(c);
      if (pos != POS_LAST) pos = pos + ONE_CHAR;
    end
    if (line_end) begin
      close_token();
      put_token(exlex_pkg::TK_END, 8'h00, pos, '0);
      clear_scan();
    end
    if (byte_toks.size() != 0) byte_toks[byte_toks.size()-1].last = 1'b1;
    tokens_due = {tokens_due, byte_toks};
  endfunction

  function automatic void check_token();
    token_due_t want;
    checked++;
    if (tokens_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] unexpected token: kind %0d chr %02h start %0d len %0d",
                 $time, out_mon.token_kind, out_mon.token_char, out_mon.start_pos,
                 out_mon.token_length);
      return;
    end
    want = tokens_due.pop_front();
    if (out_mon.token_kind !== want.tok.kind || out_mon.token_char !== want.tok.chr ||
        out_mon.start_pos !== want.tok.start || out_mon.token_length !== want.tok.length ||
        out_mon.last_of_run !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] token mismatch: exp kind %0d chr %02h start %0d len %0d last %0b",
                 $time, want.tok.kind, want.tok.chr, want.tok.start, want.tok.length,
                 want.last, " / got kind %0d chr %02h start %0d len %0d last %0b",
                 out_mon.token_kind, out_mon.token_char, out_mon.start_pos,
                 out_mon.token_length, out_mon.last_of_run);
    end
  endfunction

  // Outgoing token checked before the incoming request is predicted: tokens of
  // a request accepted at this edge cannot leave at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      tokens_due.delete();
      due_cnt_o      <= 0;
      mismatch_cnt_o <= 0;
      checked_cnt_o  <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_token();
      if (in_mon.valid && in_mon.ready)
        predict_tokens(in_mon.char_byte, in_mon.is_end, in_mon.no_char);
      due_cnt_o      <= tokens_due.size();
      mismatch_cnt_o <= mismatches;
      checked_cnt_o  <= checked;
    end
  end

endmodule

// ===== test/tb_expression_lexer_top.sv =====
// ----------------------------------------------------------------------------
// tb_expression_lexer_top
// Drives source bytes into the expression lexer with random gaps and token
// back-pressure; a checker beside the block predicts and compares each token.
// ----------------------------------------------------------------------------
module tb_expression_lexer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_BITS = exlex_pkg::POS_BITS_DEF;
  // Random lines stop once this many requests have gone in.
  localparam int unsigned RANDOM_ITEMS = 280;

  logic clk_i;
  logic rst_ni;

  exlex_in_if  src_if ();
  exlex_out_if tok_if ();

  int unsigned due_cnt;
  int unsigned mismatch_cnt;
  int unsigned checked_cnt;

  // Calm flags switch the random gaps off for a stretch on either side.
  bit          src_calm  = 1'b0;
  bit          sink_calm = 1'b0;
  int unsigned req_cnt   = 0;
  int unsigned line_cnt  = 0;

  expression_lexer_top #(
    .PosBits(POS_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (src_if),
    .out_o (tok_if)
  );

  exlex_token_checker #(
    .PosBits(POS_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (src_if),
    .out_mon       (tok_if),
    .due_cnt_o     (due_cnt),
    .mismatch_cnt_o(mismatch_cnt),
    .checked_cnt_o (checked_cnt)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Hard stop: well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Token sink: draws a random stall before taking each token.
  initial begin
    int unsigned stall;
    tok_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        tok_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tok_if.ready <= 1'b1;
      do @(posedge clk_i); while (!tok_if.valid);
    end
  end

  // One source request: optional gap, then hold valid until the block takes it.
  // After a handshake the next call drives valid exactly once in that step.
  task automatic send_item(logic [7:0] c, logic line_end, logic none);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid     <= 1'b1;
    src_if.char_byte <= c;
    src_if.is_end    <= line_end;
    src_if.no_char   <= none;
    do @(posedge clk_i); while (!src_if.ready);
    req_cnt++;
  endtask

  task automatic send_line(string s, bit end_on_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], end_on_last && i == s.len() - 1, 1'b0);
    line_cnt++;
  endtask

  // Hold the source off until every predicted token has come out.
  task automatic drain_tokens();
    src_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return "0" + 8'($urandom_range(0, 9));
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed expression lines with random content; one in eight is
  // raw byte noise. The line end rides on the last byte or comes on its own.
  task automatic random_line();
    logic [7:0] line_q[$];
    string      kw;
    string      ops;
    bit         end_apart;
    ops = "+-*/()=;";
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) line_q = {line_q, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 7)) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            line_q = {line_q, rand_letter()};
            repeat ($urandom_range(0, 5)) line_q = {line_q, rand_alnum()};
          end
          2: begin
            // keyword and near misses
            case ($urandom_range(0, 4))
              0:       kw = "const";
              1:       kw = "cons";
              2:       kw = "consts";
              3:       kw = "const7";
              default: kw = "cOnst";
            endcase
            for (int i = 0; i < kw.len(); i++) line_q = {line_q, kw[i]};
          end
          3, 4: repeat ($urandom_range(1, 5)) line_q = {line_q, rand_digit()};
          5: begin
            // number running straight into a letter
            repeat ($urandom_range(1, 3)) line_q = {line_q, rand_digit()};
            repeat ($urandom_range(1, 3)) line_q = {line_q, rand_letter()};
          end
          6, 7: line_q = {line_q, ops[$urandom_range(0, 7)]};
          8: begin
            // space or one of 09..0D
            repeat ($urandom_range(1, 3))
              line_q = {line_q, ($urandom_range(0, 1) ? 8'h20
                                                      : 8'($urandom_range(9, 13)))};
          end
          default: begin
            if ($urandom_range(0, 1)) line_q = {line_q, 8'($urandom)};
          end
        endcase
        if ($urandom_range(0, 1)) line_q = {line_q, 8'h20};
      end
    end
    end_apart = (line_q.size() == 0) || $urandom_range(0, 1);
    foreach (line_q[i]) begin
      // stray empty request without a line end
      if ($urandom_range(0, 24) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      send_item(line_q[i], !end_apart && i == line_q.size() - 1, 1'b0);
    end
    if (end_apart) send_item(8'($urandom), 1'b1, 1'b1);
    line_cnt++;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    src_if.valid     <= 1'b0;
    src_if.char_byte <= 8'h00;
    src_if.is_end    <= 1'b0;
    src_if.no_char   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---------------- directed ----------------
    // Empty request without line end: must give nothing.
    send_item(8'hFF, 1'b0, 1'b1);
    // Keyword, equal, number closed by a letter, identifier closed by ';'.
    send_line("const=12ab;", 1'b1);
    // Brackets, three operators (- * /), tab, single-letter ident, end on its own.
    send_line("(c\t-9)*/ ", 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // Error on byte 00, rest of the line dropped, end carried by byte FF.
    send_item(8'h00, 1'b0, 1'b0);
    send_item("a", 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    line_cnt++;
    // Empty source line.
    send_item(8'hA5, 1'b1, 1'b1);
    line_cnt++;

    // Let everything out before the random part.
    drain_tokens();

    // ---------------- random ----------------
    while (req_cnt < RANDOM_ITEMS) begin
      src_calm  = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      random_line();
      if ($urandom_range(0, 9) == 0) drain_tokens();
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    // ---------------- wind-down ----------------
    drain_tokens();
    repeat (20) @(posedge clk_i);

    $display("Run: %0d source requests over %0d lines: keyword, error and empty-line",
             req_cnt, line_cnt);
    $display("     cases, then random lines under gaps and stalls; %0d tokens compared.",
             checked_cnt);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
